// File: hdl/ksl_pkg.sv
// shared types and codes for the keyed slot table
`default_nettype none

package ksl_pkg;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_GET   = 2'd1;
    localparam logic [1:0] CMD_SET   = 2'd2;
    localparam logic [1:0] CMD_FREE  = 2'd3;

    // status codes
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_ALREADY   = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] owner_key;
        logic [63:0] write_value;
    } t_ksl_in;

    typedef struct packed {
        logic [63:0] read_value;
        logic [1:0]  status;
    } t_ksl_out;

    // one stored slot
    typedef struct packed {
        logic        valid;
        logic [63:0] owner;
        logic [63:0] value;
    } t_slot;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// File: hdl/keyed_slot_table.sv
// keyed slot table top level: sequencer plus slot memory
//
//   channel   direction  handshake                    payload
//   in        input      i_in_valid / o_in_stall      i_in_data  (cmd, owner_key, write_value)
//   out       output     o_out_valid / i_out_stall    o_out_data (read_value, status)
//
// every command scans all ENTRIES slots, one memory read per cycle; the single
// memory read port sets that rate
// after reset a clearing pass marks every slot free; the
// input is stalled during it
// a finished result sits in an output register, so the next transaction is
// accepted while it waits; a stalled output holds the update of the following
// transaction until the register frees up
`default_nettype none

module keyed_slot_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire ksl_pkg::t_ksl_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output ksl_pkg::t_ksl_out o_out_data
);
    import ksl_pkg::*;

    // slot address width, at least one bit for a single-slot table
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // memory ports between sequencer and storage
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_slot         rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_slot         wr_data;

    // sequencer: clearing pass, scan for key and first free slot, update
    ksl_ctrl #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // slot storage: valid bit, owner key and data word per slot
    ksl_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

`default_nettype wire

// File: hdl/ksl_mem.sv
// slot storage: one write port, one registered read port
`default_nettype none

module ksl_mem #(
    parameter int ENTRIES = 16,
    parameter int AW      = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output ksl_pkg::t_slot     o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire ksl_pkg::t_slot i_wr_data
);
    import ksl_pkg::*;

    t_slot r_mem [ENTRIES];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hdl/ksl_ctrl.sv
// command sequencer: clearing pass, slot scan, update and result register
`default_nettype none

module ksl_ctrl #(
    parameter int ENTRIES = 16,
    parameter int AW      = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ksl_pkg::t_ksl_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ksl_pkg::t_ksl_out  o_out_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  wire ksl_pkg::t_slot i_rd_data,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output ksl_pkg::t_slot     o_wr_data
);
    import ksl_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    t_state      r_state,    n_state;
    logic [CW-1:0] r_idx,    n_idx;
    logic [1:0]  r_cmd,      n_cmd;
    logic [63:0] r_key,      n_key;
    logic [63:0] r_wval,     n_wval;
    logic        r_chk,      n_chk;
    logic [AW-1:0] r_chk_idx, n_chk_idx;
    logic        r_hit,      n_hit;
    logic [AW-1:0] r_hit_idx, n_hit_idx;
    logic [63:0] r_hit_val,  n_hit_val;
    logic        r_free,     n_free;
    logic [AW-1:0] r_free_idx, n_free_idx;
    logic        r_out_vld,  n_out_vld;
    t_ksl_out    r_out,      n_out;

    logic          upd_en;
    logic [AW-1:0] upd_addr;
    t_slot         upd_data;
    t_ksl_out      res;

    // outcome of the finished scan
    always_comb begin
        upd_en         = 1'b0;
        upd_addr       = r_hit_idx;
        upd_data.valid = 1'b1;
        upd_data.owner = r_key;
        upd_data.value = '0;
        res.read_value = '0;
        res.status     = STAT_DONE;
        unique case (r_cmd)
            CMD_ALLOC: begin
                if (r_hit) begin
                    res.status = STAT_ALREADY;
                end else if (r_free) begin
                    upd_en   = 1'b1;
                    upd_addr = r_free_idx;
                end else begin
                    res.status = STAT_FULL;
                end
            end
            CMD_GET: begin
                if (r_hit) begin
                    res.read_value = r_hit_val;
                end else begin
                    res.status = STAT_NOT_FOUND;
                end
            end
            CMD_SET: begin
                if (r_hit) begin
                    upd_en         = 1'b1;
                    upd_data.value = r_wval;
                end else begin
                    res.status = STAT_NOT_FOUND;
                end
            end
            CMD_FREE: begin
                if (r_hit) begin
                    upd_en         = 1'b1;
                    upd_data.valid = 1'b0;
                end else begin
                    res.status = STAT_NOT_FOUND;
                end
            end
            default: begin
                res.status = STAT_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_wval     = r_wval;
        n_chk      = 1'b0;
        n_chk_idx  = r_chk_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_val  = r_hit_val;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_idx[AW-1:0];
        o_wr_en    = 1'b0;
        o_wr_addr  = r_idx[AW-1:0];
        o_wr_data  = '0;

        if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end

        // compare the slot read in the previous cycle
        if (r_chk) begin
            if (i_rd_data.valid && (i_rd_data.owner == r_key) && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_chk_idx;
                n_hit_val = i_rd_data.value;
            end
            if (!i_rd_data.valid && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_chk_idx;
            end
        end

        unique case (r_state)
            ST_CLEAR: begin
                o_wr_en = 1'b1;
                n_idx   = r_idx + CW'(1);
                if (r_idx == CW'(ENTRIES - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.cmd;
                    n_key   = i_in_data.owner_key;
                    n_wval  = i_in_data.write_value;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx != CW'(ENTRIES)) begin
                    o_rd_en   = 1'b1;
                    n_idx     = r_idx + CW'(1);
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx[AW-1:0];
                end else if (!r_chk) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_vld || !i_out_stall) begin
                    o_wr_en   = upd_en;
                    o_wr_addr = upd_addr;
                    o_wr_data = upd_data;
                    n_out_vld = 1'b1;
                    n_out     = res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_chk     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_chk     <= n_chk;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_wval     <= n_wval;
        r_chk_idx  <= n_chk_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_val  <= n_hit_val;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
